### src/hidr_pkg.sv
// Shared types and constants for the H.264 IDR NAL detector.
// No dependencies; imported by every module of the block.
package hidr_pkg;

    localparam int HIDR_POSITION_BITS = 24;
    localparam int HIDR_LEN_BITS      = 24;
    localparam int HIDR_CMP_BITS      = 34;   // holds start + 4 + a 32-bit length

    localparam logic [4:0] HIDR_NAL_TYPE_MASK = 5'h1f;
    localparam logic [4:0] HIDR_NAL_TYPE_IDR  = 5'd5;

    typedef enum logic [1:0] {
        PH_LEN,
        PH_HDR,
        PH_SKIP
    } hidr_phase_t;

    // Per-cycle control handed from the top level to the detectors
    typedef struct packed {
        logic take;     // input item accepted this cycle
        logic last;     // item is the final byte of the buffer
        logic active;   // position not saturated
    } hidr_step_t;

    typedef struct packed {
        logic walk_hit;
        logic sc_hit;
        logic idr;
    } hidr_res_t;

endpackage

### src/hidr_scan.sv
// Annex B start code scan: four-byte window and start-code flag.
// Depends on hidr_pkg.
module hidr_scan
    import hidr_pkg::*;
#(
    parameter int POSITION_BITS = HIDR_POSITION_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  hidr_step_t                step_i,
    input  logic [POSITION_BITS-1:0]  pos_i,
    input  logic [7:0]                byte_i,
    input  logic [HIDR_LEN_BITS-1:0]  len_i,
    output logic                      hit_o
);

    logic [31:0] recent_reg, recent_next;
    logic        found_reg, found_next;
    logic [HIDR_CMP_BITS-1:0] pos_ext, len_ext;
    logic        is_idr, hit4, hit3;

    assign pos_ext = {{(HIDR_CMP_BITS-POSITION_BITS){1'b0}}, pos_i};
    assign len_ext = {{(HIDR_CMP_BITS-HIDR_LEN_BITS){1'b0}}, len_i};
    assign is_idr  = (byte_i[4:0] & HIDR_NAL_TYPE_MASK) == HIDR_NAL_TYPE_IDR;
    assign hit4    = (recent_reg == 32'h0000_0001) && (pos_ext < len_ext);
    assign hit3    = (recent_reg[23:0] == 24'h00_0001)
                     && ((pos_ext + HIDR_CMP_BITS'(1)) < len_ext);

    always_comb begin
        hit_o       = found_reg;
        recent_next = recent_reg;
        found_next  = found_reg;
        if (step_i.take) begin
            if (step_i.active && is_idr && (hit4 || hit3)) begin
                hit_o = 1'b1;
            end
            recent_next = {recent_reg[23:0], byte_i};
            found_next  = hit_o;
            if (step_i.last) begin
                recent_next = 32'hFFFF_FFFF;
                found_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg <= 32'hFFFF_FFFF;
            found_reg  <= 1'b0;
        end else begin
            recent_reg <= recent_next;
            found_reg  <= found_next;
        end
    end

endmodule

### src/hidr_walk.sv
// Walk over units with 4-byte big-endian length prefixes.
// Depends on hidr_pkg.
module hidr_walk
    import hidr_pkg::*;
#(
    parameter int POSITION_BITS = HIDR_POSITION_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  hidr_step_t                step_i,
    input  logic [POSITION_BITS-1:0]  pos_i,
    input  logic [7:0]                byte_i,
    input  logic [HIDR_LEN_BITS-1:0]  len_i,
    output logic                      hit_o
);

    hidr_phase_t              phase_reg, phase_next;
    logic [31:0]              ulen_reg, ulen_next;
    logic [HIDR_LEN_BITS-1:0] start_reg, start_next;
    logic                     found_reg, found_next;
    logic                     stop_reg, stop_next;

    logic [HIDR_CMP_BITS-1:0] pos_ext, len_ext, start_ext, off;
    logic [HIDR_CMP_BITS-1:0] end_cur, end_new, start_plus5;
    logic [31:0]              ulen_shift;

    assign pos_ext     = {{(HIDR_CMP_BITS-POSITION_BITS){1'b0}}, pos_i};
    assign len_ext     = {{(HIDR_CMP_BITS-HIDR_LEN_BITS){1'b0}}, len_i};
    assign start_ext   = {{(HIDR_CMP_BITS-HIDR_LEN_BITS){1'b0}}, start_reg};
    assign off         = pos_ext - start_ext;
    assign ulen_shift  = {ulen_reg[23:0], byte_i};
    assign start_plus5 = start_ext + HIDR_CMP_BITS'(5);
    assign end_cur     = start_ext + HIDR_CMP_BITS'(4) + {2'b00, ulen_reg};
    assign end_new     = start_ext + HIDR_CMP_BITS'(4) + {2'b00, ulen_shift};

    always_comb begin
        hidr_phase_t ph;
        ph         = phase_reg;
        phase_next = phase_reg;
        ulen_next  = ulen_reg;
        start_next = start_reg;
        found_next = found_reg;
        stop_next  = stop_reg;
        if (step_i.take && step_i.active && !stop_reg && !found_reg) begin
            // A skipped unit ends where the next prefix begins
            if (ph == PH_SKIP && pos_ext == start_ext) begin
                ph = PH_LEN;
            end
            phase_next = ph;
            case (ph)
                PH_LEN: begin
                    if (pos_ext >= start_ext) begin
                        if (off == HIDR_CMP_BITS'(0)) begin
                            if (start_plus5 > len_ext) begin
                                stop_next = 1'b1;
                            end else begin
                                ulen_next = {24'h0, byte_i};
                            end
                        end else if (off < HIDR_CMP_BITS'(4)) begin
                            ulen_next = ulen_shift;
                            if (off == HIDR_CMP_BITS'(3)) begin
                                if (ulen_shift == 32'h0 || end_new > len_ext) begin
                                    stop_next = 1'b1;
                                end else begin
                                    phase_next = PH_HDR;
                                end
                            end
                        end
                    end
                end
                PH_HDR: begin
                    if ((byte_i[4:0] & HIDR_NAL_TYPE_MASK) == HIDR_NAL_TYPE_IDR) begin
                        found_next = 1'b1;
                    end
                    start_next = end_cur[HIDR_LEN_BITS-1:0];
                    phase_next = PH_SKIP;
                end
                PH_SKIP: begin
                end
                default: begin
                    stop_next = 1'b1;
                end
            endcase
        end
        hit_o = found_next;
        if (step_i.take && step_i.last) begin
            phase_next = PH_LEN;
            ulen_next  = 32'h0;
            start_next = '0;
            found_next = 1'b0;
            stop_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEN;
            ulen_reg  <= 32'h0;
            start_reg <= '0;
            found_reg <= 1'b0;
            stop_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            ulen_reg  <= ulen_next;
            start_reg <= start_next;
            found_reg <= found_next;
            stop_reg  <= stop_next;
        end
    end

    a_found_stop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(found_reg && stop_reg))
        else $error("walk both found and stopped");

endmodule

### src/hidr_out.sv
// Result register with one skid entry for the detector outputs.
// Depends on hidr_pkg.
module hidr_out
    import hidr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_i,
    input  hidr_res_t res_i,
    output logic      ready_o,
    output logic      m_valid_o,
    input  logic      m_ready_i,
    output hidr_res_t m_res_o
);

    logic      m_valid_reg, m_valid_next;
    hidr_res_t m_res_reg, m_res_next;
    logic      skid_valid_reg, skid_valid_next;
    hidr_res_t skid_reg, skid_next;
    logic      pop;

    assign pop       = m_valid_reg && m_ready_i;
    assign ready_o   = !skid_valid_reg;
    assign m_valid_o = m_valid_reg;
    assign m_res_o   = m_res_reg;

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_res_next      = m_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                m_res_next      = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push_i) begin
            if (!m_valid_reg || pop) begin
                m_valid_next = 1'b1;
                m_res_next   = res_i;
            end else begin
                skid_valid_next = 1'b1;
                skid_next       = res_i;
            end
        end else if (pop) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        m_res_reg <= m_res_next;
        skid_reg  <= skid_next;
    end

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry held without output entry");

    a_push_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        push_i && m_valid_reg && !pop |=> skid_valid_reg)
        else $error("result dropped while output stalled");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !pop |=> skid_valid_reg && $stable(skid_reg))
        else $error("skid entry lost while stalled");

endmodule

### src/h264_idr_nal_detector.sv
// H.264 IDR NAL detector, top level: byte counter, both detectors, result buffer.
// Result: registered into the output register when the last byte is taken, or into the skid entry while one waits.
// Throughput: one byte per cycle; s_tready drops only while two results wait unread.
// Reset (aresetn low, synchronous): position and walk state cleared, window set to all ones, result buffer emptied.
// Depends on hidr_pkg, hidr_scan, hidr_walk and hidr_out.
module h264_idr_nal_detector
    import hidr_pkg::*;
#(
    parameter int POSITION_BITS = HIDR_POSITION_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items: one buffer byte each
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [7:0] data_byte, [31:8] buffer_length
    input  logic        s_tlast,   // last_byte
    // Result items: one per buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] idr_found, [1] start_code_hit,
                                   // [2] length_walk_hit, [7:3] zero
);

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    hidr_step_t               step;
    hidr_res_t                res, m_res;
    logic                     sc_hit, walk_hit;
    logic [7:0]               data_byte;
    logic [HIDR_LEN_BITS-1:0] buf_len;

    assign data_byte = s_tdata[7:0];
    assign buf_len   = s_tdata[31:8];

    // A byte at the saturated position takes part in neither detector
    assign step.take   = s_tvalid && s_tready;
    assign step.last   = s_tlast;
    assign step.active = ~&pos_reg;

    // Advance the byte position, hold it at saturation, clear it after the last byte
    always_comb begin
        pos_next = pos_reg;
        if (step.take) begin
            if (step.last) begin
                pos_next = '0;
            end else if (step.active) begin
                pos_next = pos_reg + POSITION_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    hidr_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_i  (step),
        .pos_i   (pos_reg),
        .byte_i  (data_byte),
        .len_i   (buf_len),
        .hit_o   (sc_hit)
    );

    hidr_walk #(
        .POSITION_BITS (POSITION_BITS)
    ) u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_i  (step),
        .pos_i   (pos_reg),
        .byte_i  (data_byte),
        .len_i   (buf_len),
        .hit_o   (walk_hit)
    );

    // Both hit flags already include the current byte
    assign res.idr      = sc_hit || walk_hit;
    assign res.sc_hit   = sc_hit;
    assign res.walk_hit = walk_hit;

    hidr_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_i    (step.take && step.last),
        .res_i     (res),
        .ready_o   (s_tready),
        .m_valid_o (m_tvalid),
        .m_ready_i (m_tready),
        .m_res_o   (m_res)
    );

    assign m_tdata = {5'b0_0000, m_res.walk_hit, m_res.sc_hit, m_res.idr};

endmodule
